@@ rtl/nlr_pkg.sv @@
package nlr_pkg;

    localparam int unsigned RAMP_LENGTH_DEFAULT = 16;

    localparam int unsigned SLOT_W   = 4;
    localparam int unsigned COLOR_W  = 8;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned BRIGHT_W = 7;
    localparam int unsigned DIST_W   = 8;
    localparam int unsigned TERM_W   = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    localparam logic [COLOR_W-1:0] BLACK_INDEX = 8'd0;
    localparam logic [COLOR_W-1:0] WHITE_INDEX = 8'd31;

    localparam longint unsigned LUMA_DIV    = 5000;
    localparam int unsigned     RECIP_SHIFT = 32;
    localparam longint unsigned LUMA_RECIP  =
        ((64'd1 << RECIP_SHIFT) + LUMA_DIV - 64'd1) / LUMA_DIV;

    localparam logic [31:0] RED_KM   = 32'(64'd1063 * LUMA_RECIP);
    localparam logic [31:0] GREEN_KM = 32'(64'd3576 * LUMA_RECIP);
    localparam logic [31:0] BLUE_KM  = 32'(64'd361 * LUMA_RECIP);

    localparam int unsigned     DIV3_SHIFT = 9;
    localparam logic [TERM_W-1:0] DIV3_MUL = 8'd171;

    typedef struct packed {
        logic                valid;
        logic [BRIGHT_W-1:0] bright;
        logic [DIST_W-1:0]   best;
        logic [COLOR_W-1:0]  pick;
    } token_t;

    typedef struct packed {
        logic                en;
        logic [SLOT_W-1:0]   slot;
        logic [BRIGHT_W-1:0] bright;
        logic [COLOR_W-1:0]  color;
    } load_t;

endpackage

@@ rtl/nlr_cell.sv @@
module nlr_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  nlr_pkg::load_t  load,
    input  nlr_pkg::token_t tok_in,
    output nlr_pkg::token_t tok_out
);

    logic [nlr_pkg::BRIGHT_W-1:0] bright_reg;
    logic [nlr_pkg::COLOR_W-1:0]  color_reg;
    logic                         valid_reg;
    logic [nlr_pkg::BRIGHT_W-1:0] y_reg;
    logic [nlr_pkg::DIST_W-1:0]   best_reg;
    logic [nlr_pkg::COLOR_W-1:0]  pick_reg;

    logic                         hit;
    logic [nlr_pkg::BRIGHT_W-1:0] distance;
    logic                         take;

    assign hit      = load.en && (32'(load.slot) == INDEX);
    assign distance = (tok_in.bright >= bright_reg) ? (tok_in.bright - bright_reg)
                                                    : (bright_reg - tok_in.bright);
    assign take     = {1'b0, distance} < tok_in.best;

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            bright_reg <= load.bright;
            color_reg  <= load.color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= tok_in.bright;
        best_reg <= take ? {1'b0, distance} : tok_in.best;
        pick_reg <= take ? color_reg : tok_in.pick;
    end

    assign tok_out.valid  = valid_reg;
    assign tok_out.bright = y_reg;
    assign tok_out.best   = best_reg;
    assign tok_out.pick   = pick_reg;

endmodule

@@ rtl/nearest_luminance_ramp_remap.sv @@
// Remaps palette colors onto a ramp of color slots by nearest brightness.
// Input channel s_*: one item per handshake. s_tuser is the operation: a load
// item writes the slot given in s_tdata with its palette index and the
// brightness of its RGB and gives no result; a map item gives one result on
// m_*, the palette index of the ramp slot whose brightness is closest (lowest
// slot on a tie). Palette indices 0 and 31 map to themselves.
// Sequence: an accepted item passes through the TERMS, LUMA and DISPATCH states;
// a load item then ends, a map item of index 0 or 31 goes on to DELIVER, and any
// other map item waits in SEARCH for the search token walking the chain of ramp
// cells, one cell a cycle, before DELIVER. One item is in work at a time, so a new
// item is accepted only once the block is back in IDLE.
// The result sits in an output register; the block takes the next item while
// it waits. If the receiver stalls, a finished second result waits inside the
// block and no further item is accepted until the first one is taken.
// Reset clears control state only; every ramp slot must be loaded before a
// map item compares against it.
module nearest_luminance_ramp_remap #(
    parameter int unsigned RAMP_LENGTH = nlr_pkg::RAMP_LENGTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // slot, color_index, red, green, blue, zero pad
    input  logic [0:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // mapped_index
);

    typedef enum logic [2:0] {
        IDLE,
        TERMS,
        LUMA,
        DISPATCH,
        SEARCH,
        DELIVER
    } state_t;

    state_t state_reg;

    logic                          op_reg;
    logic [nlr_pkg::SLOT_W-1:0]    slot_reg;
    logic [nlr_pkg::COLOR_W-1:0]   cidx_reg;
    logic [nlr_pkg::CHAN_W-1:0]    red_reg;
    logic [nlr_pkg::CHAN_W-1:0]    green_reg;
    logic [nlr_pkg::CHAN_W-1:0]    blue_reg;
    logic [nlr_pkg::TERM_W-1:0]    red_term_reg;
    logic [nlr_pkg::TERM_W-1:0]    green_term_reg;
    logic [nlr_pkg::TERM_W-1:0]    blue_term_reg;
    logic [nlr_pkg::BRIGHT_W-1:0]  y_reg;
    logic [nlr_pkg::COLOR_W-1:0]   result_reg;
    logic                          m_tvalid_reg;
    logic [nlr_pkg::COLOR_W-1:0]   m_tdata_reg;

    logic [39:0]                   red_prod;
    logic [39:0]                   green_prod;
    logic [39:0]                   blue_prod;
    logic [nlr_pkg::TERM_W:0]      term_sum;
    logic [16:0]                   div3_prod;
    logic                          special;

    nlr_pkg::load_t                load;
    nlr_pkg::token_t               tok [RAMP_LENGTH+1];
    logic [RAMP_LENGTH:1]          tok_valid;

    assign red_prod   = 40'(red_reg) * 40'(nlr_pkg::RED_KM);
    assign green_prod = 40'(green_reg) * 40'(nlr_pkg::GREEN_KM);
    assign blue_prod  = 40'(blue_reg) * 40'(nlr_pkg::BLUE_KM);

    assign term_sum  = (nlr_pkg::TERM_W+1)'(red_term_reg) + (nlr_pkg::TERM_W+1)'(green_term_reg)
                     + (nlr_pkg::TERM_W+1)'(blue_term_reg);
    assign div3_prod = 17'(term_sum) * 17'(nlr_pkg::DIV3_MUL);

    assign special = (cidx_reg == nlr_pkg::BLACK_INDEX) || (cidx_reg == nlr_pkg::WHITE_INDEX);

    assign load.en     = (state_reg == DISPATCH) && (op_reg == nlr_pkg::OP_LOAD);
    assign load.slot   = slot_reg;
    assign load.bright = y_reg;
    assign load.color  = cidx_reg;

    assign tok[0].valid  = (state_reg == DISPATCH) && (op_reg == nlr_pkg::OP_MAP) && !special;
    assign tok[0].bright = y_reg;
    assign tok[0].best   = '1;
    assign tok[0].pick   = '0;

    for (genvar i = 0; i < RAMP_LENGTH; i++)
    begin : g_cell
        nlr_cell #(
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .load    (load),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
        assign tok_valid[i+1] = tok[i+1].valid;
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != DELIVER))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= s_tuser[0];
                        slot_reg  <= s_tdata[3:0];
                        cidx_reg  <= s_tdata[11:4];
                        red_reg   <= s_tdata[19:12];
                        green_reg <= s_tdata[27:20];
                        blue_reg  <= s_tdata[35:28];
                        state_reg <= TERMS;
                    end
                end
                TERMS:
                begin
                    red_term_reg   <= red_prod[nlr_pkg::RECIP_SHIFT +: nlr_pkg::TERM_W];
                    green_term_reg <= green_prod[nlr_pkg::RECIP_SHIFT +: nlr_pkg::TERM_W];
                    blue_term_reg  <= blue_prod[nlr_pkg::RECIP_SHIFT +: nlr_pkg::TERM_W];
                    state_reg      <= LUMA;
                end
                LUMA:
                begin
                    y_reg     <= div3_prod[nlr_pkg::DIV3_SHIFT +: nlr_pkg::BRIGHT_W];
                    state_reg <= DISPATCH;
                end
                DISPATCH:
                begin
                    if (op_reg == nlr_pkg::OP_LOAD)
                    begin
                        state_reg <= IDLE;
                    end
                    else if (special)
                    begin
                        result_reg <= cidx_reg;
                        state_reg  <= DELIVER;
                    end
                    else
                    begin
                        state_reg <= SEARCH;
                    end
                end
                SEARCH:
                begin
                    if (tok[RAMP_LENGTH].valid)
                    begin
                        result_reg <= tok[RAMP_LENGTH].pick;
                        state_reg  <= DELIVER;
                    end
                end
                DELIVER:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= result_reg;
                        state_reg    <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valid) <= 1)
        else $error("more than one search token in the ramp chain");

    a_exit_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tok[RAMP_LENGTH].valid |-> (state_reg == SEARCH))
        else $error("search token left the chain outside the search state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == TERMS))
        else $error("accepted item did not start brightness computation");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result was overwritten");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned SLOT_W       = nlr_pkg::SLOT_W;
    localparam int unsigned COLOR_W      = nlr_pkg::COLOR_W;
    localparam int unsigned CHAN_W       = nlr_pkg::CHAN_W;
    localparam int unsigned BRIGHT_W     = nlr_pkg::BRIGHT_W;
    localparam int unsigned RAMP_SLOTS   = nlr_pkg::RAMP_LENGTH_DEFAULT;
    localparam int unsigned RANDOM_ITEMS = 830;
    localparam int unsigned CALM_ITEMS   = 120;
    localparam int unsigned DRAIN_CYCLES = 2 * (RAMP_SLOTS + 6);
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic                op;
        logic [SLOT_W-1:0]   slot;
        logic [COLOR_W-1:0]  color_index;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic                known;
        logic [COLOR_W-1:0]  mapped;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // slot, color_index, red, green, blue, zero pad
    logic [0:0]  s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // mapped_index

    logic [BRIGHT_W-1:0] ramp_luma [RAMP_SLOTS];
    logic [COLOR_W-1:0]  ramp_index [RAMP_SLOTS];
    logic [COLOR_W-1:0]  pending_mapped [$];
    logic [COLOR_W-1:0]  expected_index;
    int unsigned         mismatch_count = 0;
    int unsigned         cycle_count = 0;
    bit                  calm = 1'b0;

    nearest_luminance_ramp_remap uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    function automatic logic [BRIGHT_W-1:0] brightness_of(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        int unsigned sum;
        sum = (1063 * int'(r)) / 5000 + (3576 * int'(g)) / 5000 + (361 * int'(b)) / 5000;
        return BRIGHT_W'(sum / 3);
    endfunction

    function automatic logic [COLOR_W-1:0] nearest_ramp_index(input logic [BRIGHT_W-1:0] y);
        int unsigned best_dist;
        int unsigned gap_dist;
        logic [COLOR_W-1:0] pick;
        best_dist = 256;
        pick = '0;
        for (int j = 0; j < RAMP_SLOTS; j++)
        begin
            gap_dist = (y >= ramp_luma[j]) ? int'(y - ramp_luma[j]) : int'(ramp_luma[j] - y);
            if (gap_dist < best_dist)
            begin
                best_dist = gap_dist;
                pick = ramp_index[j];
            end
        end
        return pick;
    endfunction

    function automatic stim_row_t row(
        input logic               op,
        input logic [SLOT_W-1:0]  slot,
        input logic [COLOR_W-1:0] color_index,
        input logic [CHAN_W-1:0]  red,
        input logic [CHAN_W-1:0]  green,
        input logic [CHAN_W-1:0]  blue,
        input logic               known,
        input logic [COLOR_W-1:0] mapped
    );
        stim_row_t it;
        it.op = op;
        it.slot = slot;
        it.color_index = color_index;
        it.red = red;
        it.green = green;
        it.blue = blue;
        it.known = known;
        it.mapped = mapped;
        return it;
    endfunction

    function automatic void predict(input stim_row_t it);
        if (it.op == nlr_pkg::OP_LOAD)
        begin
            if (it.slot < RAMP_SLOTS)
            begin
                ramp_luma[it.slot] = brightness_of(it.red, it.green, it.blue);
                ramp_index[it.slot] = it.color_index;
            end
        end
        else if (it.known)
        begin
            pending_mapped.push_back(it.mapped);
        end
        else if (it.color_index == nlr_pkg::BLACK_INDEX
                 || it.color_index == nlr_pkg::WHITE_INDEX)
        begin
            pending_mapped.push_back(it.color_index);
        end
        else
        begin
            pending_mapped.push_back(
                nearest_ramp_index(brightness_of(it.red, it.green, it.blue)));
        end
    endfunction

    // The valid line is only lowered when a gap follows, so a back-to-back
    // item never sees valid dropped and raised within one time step.
    task automatic send_item(input stim_row_t it);
        int unsigned gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap != 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tuser  <= it.op;
        s_tdata  <= {4'b0, it.blue, it.green, it.red, it.color_index, it.slot};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict(it);
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_mapped.size() == 0)
            begin
                $display("%0t: unexpected mapped_index, expected none, actual %0d",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                expected_index = pending_mapped.pop_front();
                if (m_tdata !== expected_index)
                begin
                    $display("%0t: mapped_index mismatch, expected %0d, actual %0d",
                             $time, expected_index, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        stim_row_t          directed [$];
        stim_row_t          it;
        logic [CHAN_W-1:0]  gray;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;

        // Black and white pass through before any ramp slot exists.
        directed.push_back(row(nlr_pkg::OP_MAP, 4'h0, nlr_pkg::BLACK_INDEX,
                               8'hFF, 8'hFF, 8'hFF, 1'b1, nlr_pkg::BLACK_INDEX));
        directed.push_back(row(nlr_pkg::OP_MAP, 4'hF, nlr_pkg::WHITE_INDEX,
                               8'h00, 8'h00, 8'h00, 1'b1, nlr_pkg::WHITE_INDEX));
        // A gray ramp from black to white, palette indices running downward.
        for (int s = 0; s < RAMP_SLOTS; s++)
        begin
            directed.push_back(row(nlr_pkg::OP_LOAD, SLOT_W'(s), COLOR_W'(255 - 17 * s),
                                   CHAN_W'(17 * s), CHAN_W'(17 * s), CHAN_W'(17 * s),
                                   1'b0, '0));
        end
        // Slot 9 now matches slot 8 in brightness, so slot 8 has to win the tie.
        directed.push_back(row(nlr_pkg::OP_LOAD, 4'd9, 8'h5A, 8'd136, 8'd136, 8'd136,
                               1'b0, '0));
        directed.push_back(row(nlr_pkg::OP_MAP, 4'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0));
        directed.push_back(row(nlr_pkg::OP_MAP, 4'hF, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0, '0));
        directed.push_back(row(nlr_pkg::OP_MAP, 4'h5, 8'h40, 8'd136, 8'd136, 8'd136,
                               1'b0, '0));
        directed.push_back(row(nlr_pkg::OP_MAP, 4'hA, 8'h80, 8'hFF, 8'h00, 8'h00, 1'b0, '0));
        directed.push_back(row(nlr_pkg::OP_MAP, 4'h3, 8'h7F, 8'h00, 8'hFF, 8'h00, 1'b0, '0));
        directed.push_back(row(nlr_pkg::OP_MAP, 4'hC, 8'hFE, 8'h00, 8'h00, 8'hFF, 1'b0, '0));

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i]) send_item(directed[i]);

        // Every slot is loaded by now, so any map item is within the contract.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            it.op = ($urandom_range(0, 3) == 0) ? nlr_pkg::OP_LOAD : nlr_pkg::OP_MAP;
            it.slot = SLOT_W'($urandom_range(0, 15));
            if (it.op == nlr_pkg::OP_MAP && $urandom_range(0, 9) == 0)
                it.color_index = $urandom_range(0, 1) ? nlr_pkg::WHITE_INDEX
                                                      : nlr_pkg::BLACK_INDEX;
            else
                it.color_index = COLOR_W'($urandom);
            // Grays on the ramp's own grid make exact ties frequent.
            if ($urandom_range(0, 1))
            begin
                gray = CHAN_W'(17 * $urandom_range(0, 15));
                it.red = gray;
                it.green = gray;
                it.blue = gray;
            end
            else
            begin
                it.red = CHAN_W'($urandom);
                it.green = CHAN_W'($urandom);
                it.blue = CHAN_W'($urandom);
            end
            it.known = 1'b0;
            it.mapped = '0;
            send_item(it);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (pending_mapped.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_mapped.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
